### hw/rtl/motk_pkg.sv
package motk_pkg;

  localparam int unsigned MaxEntries = 16;
  localparam int unsigned NumObj     = 5;
  localparam int unsigned NumMin     = 3;
  localparam int unsigned IdxW       = 48;
  localparam int unsigned ValW       = 48;
  localparam int unsigned PosW       = $clog2(MaxEntries);
  localparam int unsigned CntW       = $clog2(MaxEntries + 1);
  localparam int unsigned CapW       = 5;
  localparam int unsigned ObjW       = 3;

  localparam logic [ValW-1:0] QMostNeg = {1'b1, {(ValW-1){1'b0}}};
  localparam logic [ValW-1:0] QMostPos = {1'b0, {(ValW-1){1'b1}}};

  typedef enum logic {
    ModeConsider = 1'b0,
    ModeReadout  = 1'b1
  } mode_e;

  typedef struct packed {
    logic                   mode;
    logic [ObjW-1:0]        objective_select;
    logic [IdxW-1:0]        param_index;
    logic signed [ValW-1:0] capex_value;
    logic signed [ValW-1:0] annual_cost_value;
    logic signed [ValW-1:0] payback_value;
    logic signed [ValW-1:0] cost_balance_value;
    logic signed [ValW-1:0] carbon_balance_value;
  } in_item_t;

  typedef struct packed {
    logic [IdxW-1:0]        result_index;
    logic signed [ValW-1:0] result_value;
    logic                   is_worst;
    logic                   last;
  } out_item_t;

  // command from the sequencer to every lane
  typedef struct packed {
    logic            consider;
    logic [PosW-1:0] rd_pos;
    logic [CntW-1:0] cap;
  } lane_cmd_t;

  // per-lane status back to the merge stage
  typedef struct packed {
    logic [CntW-1:0]        count;
    logic [IdxW-1:0]        rd_index;
    logic signed [ValW-1:0] rd_value;
    logic [IdxW-1:0]        worst_index;
    logic signed [ValW-1:0] worst_value;
  } lane_stat_t;

  typedef enum logic [1:0] {
    StIdle,
    StConsider,
    StRead,
    StWorst
  } seq_state_e;

endpackage

### hw/rtl/motk_lane.sv
module motk_lane (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           is_min_i,
  input  motk_pkg::lane_cmd_t            cmd_i,
  input  logic signed [motk_pkg::ValW-1:0] value_i,
  input  logic [motk_pkg::IdxW-1:0]      index_i,
  output motk_pkg::lane_stat_t           stat_o
);

  logic signed [motk_pkg::ValW-1:0] val_q [motk_pkg::MaxEntries];
  logic [motk_pkg::IdxW-1:0]        idx_q [motk_pkg::MaxEntries];
  logic signed [motk_pkg::ValW-1:0] val_d [motk_pkg::MaxEntries];
  logic [motk_pkg::IdxW-1:0]        idx_d [motk_pkg::MaxEntries];
  logic signed [motk_pkg::ValW-1:0] src_val [motk_pkg::MaxEntries];
  logic [motk_pkg::IdxW-1:0]        src_idx [motk_pkg::MaxEntries];
  logic [motk_pkg::MaxEntries-1:0]  le_src;
  logic [motk_pkg::CntW-1:0]        cnt_q, cnt_d;
  logic signed [motk_pkg::ValW-1:0] wval_q;
  logic [motk_pkg::IdxW-1:0]        widx_q;
  logic                             do_ins, drop_front;
  logic [motk_pkg::CntW-1:0]        n_eff;
  logic                             full;
  logic [motk_pkg::PosW-1:0]        last_pos;

  assign full     = (cnt_q >= cmd_i.cap);
  assign last_pos = motk_pkg::PosW'(cnt_q - 1'b1);

  // accept decision per table policy
  always_comb begin
    do_ins     = 1'b0;
    drop_front = 1'b0;
    n_eff      = cnt_q;
    if (!full) begin
      do_ins = 1'b1;
    end else if (cnt_q != '0) begin
      if (is_min_i) begin
        if (val_q[last_pos] > value_i) begin
          do_ins = 1'b1;
          n_eff  = cnt_q - 1'b1;
        end
      end else if (val_q[0] < value_i) begin
        do_ins     = 1'b1;
        drop_front = 1'b1;
        n_eff      = cnt_q - 1'b1;
      end
    end
  end

  // kept entries after an optional front drop
  always_comb begin
    for (int j = 0; j < motk_pkg::MaxEntries - 1; j++) begin
      src_val[j] = drop_front ? val_q[j+1] : val_q[j];
      src_idx[j] = drop_front ? idx_q[j+1] : idx_q[j];
    end
    src_val[motk_pkg::MaxEntries-1] = val_q[motk_pkg::MaxEntries-1];
    src_idx[motk_pkg::MaxEntries-1] = idx_q[motk_pkg::MaxEntries-1];
  end

  // compare every kept entry against the new value in parallel
  always_comb begin
    for (int j = 0; j < motk_pkg::MaxEntries; j++) begin
      le_src[j] = (motk_pkg::CntW'(j) < n_eff) && !(src_val[j] > value_i);
    end
  end

  // shift network: insert after all entries <= value
  always_comb begin
    for (int k = 0; k < motk_pkg::MaxEntries; k++) begin
      val_d[k] = val_q[k];
      idx_d[k] = idx_q[k];
    end
    cnt_d = cnt_q;
    if (cmd_i.consider && do_ins) begin
      cnt_d    = n_eff + 1'b1;
      val_d[0] = le_src[0] ? src_val[0] : value_i;
      idx_d[0] = le_src[0] ? src_idx[0] : index_i;
      for (int k = 1; k < motk_pkg::MaxEntries; k++) begin
        if (le_src[k]) begin
          val_d[k] = src_val[k];
          idx_d[k] = src_idx[k];
        end else if (le_src[k-1]) begin
          // first slot past the smaller-or-equal run takes the new entry
          val_d[k] = value_i;
          idx_d[k] = index_i;
        end else if (motk_pkg::CntW'(k) <= n_eff) begin
          val_d[k] = src_val[k-1];
          idx_d[k] = src_idx[k-1];
        end
      end
    end
  end

  // table registers: payload without reset
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < motk_pkg::MaxEntries; k++) begin
      val_q[k] <= val_d[k];
      idx_q[k] <= idx_d[k];
    end
  end

  // count and worst record
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      wval_q <= is_min_i ? motk_pkg::QMostNeg : motk_pkg::QMostPos;
      widx_q <= '0;
    end else if (cmd_i.consider) begin
      cnt_q <= cnt_d;
      if (is_min_i ? (value_i > wval_q) : (value_i < wval_q)) begin
        wval_q <= value_i;
        widx_q <= index_i;
      end
    end
  end

  assign stat_o.count       = cnt_q;
  assign stat_o.rd_index    = idx_q[cmd_i.rd_pos];
  assign stat_o.rd_value    = val_q[cmd_i.rd_pos];
  assign stat_o.worst_index = widx_q;
  assign stat_o.worst_value = wval_q;

endmodule

### hw/rtl/multi_objective_top_k_tracker.sv
// operation: a consider item is accepted, then all five lane tables update
// in parallel; a readout of a valid objective gives one result per cycle,
// while the output does not stall, for the n table entries, then the worst
// entry; a readout of an invalid objective gives no output
// throughput: one item in flight; a new item is stalled until the last
// result has left the output register; reset: tables empty, worst records at
// their extremes, capacity 16
module multi_objective_top_k_tracker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  motk_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output motk_pkg::out_item_t  out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [motk_pkg::CapW-1:0] cfg_data_i
);

  motk_pkg::seq_state_e state_q, state_d;
  motk_pkg::in_item_t   item_q;
  logic [motk_pkg::CapW-1:0] cap_q;
  logic [motk_pkg::CntW-1:0] cap_eff;
  logic [motk_pkg::CntW-1:0] k_q, k_d;
  motk_pkg::lane_cmd_t  cmd;
  motk_pkg::lane_stat_t stat [motk_pkg::NumObj];
  motk_pkg::lane_stat_t sel;
  logic signed [motk_pkg::ValW-1:0] lane_val [motk_pkg::NumObj];
  logic [motk_pkg::ObjW-1:0] obj;
  logic obj_min, accept, emit, obj_ok;
  logic [motk_pkg::CntW-1:0] n_sel;
  logic out_valid_q;
  motk_pkg::out_item_t out_q;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != motk_pkg::StIdle) || out_valid_q;
  assign cfg_ready_o = 1'b1;
  assign obj         = item_q.objective_select;
  assign obj_ok      = (obj < motk_pkg::ObjW'(motk_pkg::NumObj));
  assign obj_min     = (obj < motk_pkg::ObjW'(motk_pkg::NumMin));
  assign emit        = !out_valid_q || !out_stall_i;

  // clamp capacity into 1..MaxEntries
  always_comb begin
    if (cap_q == '0) cap_eff = motk_pkg::CntW'(1);
    else if (motk_pkg::CntW'(cap_q) > motk_pkg::CntW'(motk_pkg::MaxEntries))
      cap_eff = motk_pkg::CntW'(motk_pkg::MaxEntries);
    else cap_eff = motk_pkg::CntW'(cap_q);
  end

  assign lane_val[0] = item_q.capex_value;
  assign lane_val[1] = item_q.annual_cost_value;
  assign lane_val[2] = item_q.payback_value;
  assign lane_val[3] = item_q.cost_balance_value;
  assign lane_val[4] = item_q.carbon_balance_value;

  // merge: pick the selected lane
  always_comb begin
    sel = stat[0];
    for (int o = 0; o < motk_pkg::NumObj; o++) begin
      if (obj == motk_pkg::ObjW'(o)) sel = stat[o];
    end
  end
  assign n_sel = sel.count;

  assign cmd.consider = (state_q == motk_pkg::StConsider);
  assign cmd.cap      = cap_eff;
  assign cmd.rd_pos   = obj_min ? motk_pkg::PosW'(k_q)
                                : motk_pkg::PosW'(n_sel - 1'b1 - k_q);

  for (genvar g = 0; g < motk_pkg::NumObj; g++) begin : g_lane
    motk_lane u_lane (
      .clk_i, .rst_ni,
      .is_min_i (g < motk_pkg::NumMin),
      .cmd_i    (cmd),
      .value_i  (lane_val[g]),
      .index_i  (item_q.param_index),
      .stat_o   (stat[g])
    );
  end

  // next state
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    unique case (state_q)
      motk_pkg::StIdle: begin
        k_d = '0;
        if (accept) begin
          state_d = (in_item_i.mode == motk_pkg::ModeConsider) ?
                    motk_pkg::StConsider : motk_pkg::StRead;
        end
      end
      motk_pkg::StConsider: state_d = motk_pkg::StIdle;
      motk_pkg::StRead: begin
        if (!obj_ok) state_d = motk_pkg::StIdle;
        else if (k_q >= n_sel) state_d = motk_pkg::StWorst;
        else if (emit) k_d = k_q + 1'b1;
      end
      motk_pkg::StWorst: if (emit) state_d = motk_pkg::StIdle;
      default: state_d = motk_pkg::StIdle;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= motk_pkg::StIdle;
      k_q         <= '0;
      cap_q       <= motk_pkg::CapW'(16);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      if (cfg_valid_i && cfg_ready_o) cap_q <= cfg_data_i;
      if (emit) begin
        out_valid_q <= ((state_q == motk_pkg::StRead) && obj_ok && (k_q < n_sel)) ||
                       (state_q == motk_pkg::StWorst);
      end
    end
  end

  // item capture and output register
  always_ff @(posedge clk_i) begin
    if (accept) item_q <= in_item_i;
    if (emit) begin
      if (state_q == motk_pkg::StWorst) begin
        out_q <= '{sel.worst_index, sel.worst_value, 1'b1, 1'b1};
      end else begin
        out_q <= '{sel.rd_index, sel.rd_value, 1'b0, 1'b0};
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != motk_pkg::StIdle) |-> in_stall_o) else $error("accept while busy");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("stalled output changed");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.last) |-> out_item_o.is_worst) else $error("last not worst");
  a_cons: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == motk_pkg::StConsider) |=> (state_q == motk_pkg::StIdle))
    else $error("consider overran");

endmodule
